// File: rtl/fpsb_pkg.sv
// Shared constants, result types and the divide-by-five helper for the
// five-point stencil blur. No dependencies; used by every rtl file.
package fpsb_pkg;

  // Field widths fixed by the stream format.
  localparam int SAMPLE_BITS = 16;
  localparam int SUM_W       = SAMPLE_BITS + 3;   // five samples summed
  localparam int OUT_ROW_W   = 12;
  localparam int OUT_COL_W   = 10;

  // Configuration registers.
  localparam int GW_W       = 11;
  localparam int GH_W       = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic [GW_W-1:0] GRID_WIDTH_RESET  = 11'd1024;
  localparam logic [GH_W-1:0] GRID_HEIGHT_RESET = 13'd1024;

  // Defaults for the top-level size parameters.
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  // x / 5 as (x * ceil(2^22 / 5)) >> 22, exact for x below 2^19.
  localparam int DIV5_MUL_W = 20;
  localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 20'd838861;
  localparam int DIV5_SHIFT = 22;
  localparam int DIV5_PROD_W = SUM_W + DIV5_MUL_W;

  typedef struct packed {
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic [SUM_W-1:0]     sum;
  } result_t;

  // Up to three results caused by one sample, in delivery order by slot.
  typedef struct packed {
    logic [2:0]    mask;
    result_t [2:0] res;
  } bundle_t;

  function automatic logic [SAMPLE_BITS-1:0] div5(input logic [SUM_W-1:0] x);
    logic [DIV5_PROD_W-1:0] prod;
    prod = DIV5_PROD_W'(x) * DIV5_PROD_W'(DIV5_MUL);
    return SAMPLE_BITS'(prod >> DIV5_SHIFT);
  endfunction

endpackage

// File: rtl/five_point_stencil_blur.sv
// Top level of the five-point stencil blur: raster sample intake, line store
// addressing and stencil sums. Depends on fpsb_pkg, fpsb_line_store and
// fpsb_result_queue.
//
// Samples of a grid_width by grid_height frame enter in raster order, one per
// request; each result carries the row, column and truncated five-point
// average of one cell, with edge neighbours replaced by the cell itself. The
// block accepts one request per clock, unless the output stalls, while each
// sample yields at most one result, which holds on every row but the last.
// On the last row a sample past the first column yields two results (three
// at the last column), and requests are held back while the output register,
// which delivers one result per cycle unless stalled, drains the bundle. For
// the request that completes a result, the line store read lands in the
// cycle after acceptance, the sums are then captured into the result bundle,
// and the divide by five feeds the output register. The two line stores need
// no clearing pass after reset; a configuration write restarts the frame,
// with the stores keeping their contents.
module five_point_stencil_blur #(
  parameter int MAX_WIDTH  = fpsb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fpsb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fpsb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fpsb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [fpsb_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [fpsb_pkg::OUT_ROW_W-1:0]   out_row_o,
  output logic [fpsb_pkg::OUT_COL_W-1:0]   out_col_o,
  output logic [fpsb_pkg::SAMPLE_BITS-1:0] average_o,
  output logic                             last_of_run_o
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int LW_W = CW + 1;
  localparam int LH_W = RW + 1;
  localparam int SB   = fpsb_pkg::SAMPLE_BITS;
  localparam int SW   = fpsb_pkg::SUM_W;

  // Position flags of one sample, worked out at acceptance.
  typedef struct packed {
    logic has_up;     // row at least one: completes the cell above
    logic row_ge2;
    logic col_ge1;
    logic col_ge2;
    logic last_row;
    logic last_col;
  } pos_flags_t;

  // Configuration and frame position.
  logic [fpsb_pkg::GW_W-1:0] gw_q;
  logic [fpsb_pkg::GH_W-1:0] gh_q;
  logic [CW-1:0]             col_q;
  logic [RW-1:0]             row_q;
  logic                      sel_q;
  logic [SB-1:0]             rec0_q, rec1_q;

  logic [31:0]   gw_ext, gh_ext, lw_wide, lh_wide;
  logic [LW_W-1:0] lw, c_next;
  logic [LH_W-1:0] lh, r_next;
  logic          last_col, last_row;
  logic [CW-1:0] col_right;
  logic          in_accept;

  // Sample in flight while the line store read lands.
  logic          m_valid_q;
  logic [RW-1:0] m_row_q;
  logic [CW-1:0] m_col_q;
  logic [SB-1:0] m_s_q, m_p1_q, m_p2_q;
  pos_flags_t    m_flags_q;
  logic [SB-1:0] prev_news_q;
  logic          m_adv;

  logic [SB-1:0] news_c, news_r, olds_c;
  logic [SB-1:0] n_left, up_a, left_b, up_b, left_c, up_c;
  logic          has_b, has_c;
  fpsb_pkg::bundle_t bundle;
  logic          rq_free;
  logic          rq_load;

  // Clamp the configured size into one .. max.
  always_comb begin
    gw_ext = 32'(gw_q);
    gh_ext = 32'(gh_q);
    priority if (gw_ext == 32'd0) begin
      lw_wide = 32'd1;
    end else if (gw_ext > 32'(MAX_WIDTH)) begin
      lw_wide = 32'(MAX_WIDTH);
    end else begin
      lw_wide = gw_ext;
    end
    priority if (gh_ext == 32'd0) begin
      lh_wide = 32'd1;
    end else if (gh_ext > 32'(MAX_HEIGHT)) begin
      lh_wide = 32'(MAX_HEIGHT);
    end else begin
      lh_wide = gh_ext;
    end
  end

  assign lw        = LW_W'(lw_wide);
  assign lh        = LH_W'(lh_wide);
  assign c_next    = LW_W'(col_q) + LW_W'(1);
  assign r_next    = LH_W'(row_q) + LH_W'(1);
  assign last_col  = (c_next == lw);
  assign last_row  = (r_next == lh);
  // Right neighbour clamps to the cell itself at the last column.
  assign col_right = last_col ? col_q : CW'(c_next);

  // Hold the request while the bundle stage cannot take the sample ahead.
  assign in_stall_o = m_valid_q && !m_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Frame position and configuration; a register write restarts the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q   <= fpsb_pkg::GRID_WIDTH_RESET;
      gh_q   <= fpsb_pkg::GRID_HEIGHT_RESET;
      col_q  <= '0;
      row_q  <= '0;
      sel_q  <= 1'b0;
      rec0_q <= '0;
      rec1_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fpsb_pkg::REG_GRID_WIDTH:  gw_q <= cfg_data_i[fpsb_pkg::GW_W-1:0];
        fpsb_pkg::REG_GRID_HEIGHT: gh_q <= cfg_data_i[fpsb_pkg::GH_W-1:0];
      endcase
      col_q  <= '0;
      row_q  <= '0;
      sel_q  <= 1'b0;
      rec0_q <= '0;
      rec1_q <= '0;
    end else if (in_accept) begin
      if (last_col) begin
        // Next row, the row just written now newer; wrap after the last row.
        col_q  <= '0;
        rec0_q <= '0;
        rec1_q <= '0;
        if (last_row) begin
          row_q <= '0;
          sel_q <= 1'b0;
        end else begin
          row_q <= RW'(r_next);
          sel_q <= ~sel_q;
        end
      end else begin
        col_q  <= CW'(c_next);
        rec0_q <= sample_i;
        rec1_q <= rec0_q;
      end
    end
  end

  // Replace the older row entry and fetch the stencil column in one access.
  fpsb_line_store #(
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .access_i  (in_accept),
    .sel_i     (sel_q),
    .addr_c_i  (col_q),
    .addr_r_i  (col_right),
    .wr_data_i (sample_i),
    .news_c_o  (news_c),
    .news_r_o  (news_r),
    .olds_c_o  (olds_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (in_accept) begin
      m_valid_q <= 1'b1;
    end else if (m_adv) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      m_row_q            <= row_q;
      m_col_q            <= col_q;
      m_s_q              <= sample_i;
      m_p1_q             <= rec0_q;
      m_p2_q             <= rec1_q;
      m_flags_q.has_up   <= (row_q != '0);
      m_flags_q.row_ge2  <= (row_q > RW'(1));
      m_flags_q.col_ge1  <= (col_q != '0);
      m_flags_q.col_ge2  <= (col_q > CW'(1));
      m_flags_q.last_row <= last_row;
      m_flags_q.last_col <= last_col;
    end
    // Keep the newer-row value of this column as the left neighbour of the next.
    if (m_adv) begin
      prev_news_q <= news_c;
    end
  end

  // Stencil operands with edge replacement.
  assign n_left = m_flags_q.col_ge1 ? prev_news_q : news_c;
  assign up_a   = m_flags_q.row_ge2 ? olds_c : news_c;
  assign has_b  = m_flags_q.last_row && m_flags_q.col_ge1;
  assign left_b = m_flags_q.col_ge2 ? m_p2_q : m_p1_q;
  assign up_b   = m_flags_q.has_up ? prev_news_q : m_p1_q;
  assign has_c  = m_flags_q.last_row && m_flags_q.last_col;
  assign left_c = m_flags_q.col_ge1 ? m_p1_q : m_s_q;
  assign up_c   = m_flags_q.has_up ? news_c : m_s_q;

  always_comb begin
    bundle.mask = {has_c, has_b, m_flags_q.has_up};
    // Cell above this sample.
    bundle.res[0].row = fpsb_pkg::OUT_ROW_W'(m_row_q - RW'(1));
    bundle.res[0].col = fpsb_pkg::OUT_COL_W'(m_col_q);
    bundle.res[0].sum = SW'(n_left) + SW'(news_c) + SW'(news_r) + SW'(up_a) + SW'(m_s_q);
    // Cell to the left on the last row.
    bundle.res[1].row = fpsb_pkg::OUT_ROW_W'(m_row_q);
    bundle.res[1].col = fpsb_pkg::OUT_COL_W'(m_col_q - CW'(1));
    bundle.res[1].sum = SW'(left_b) + SW'(m_p1_q) + SW'(m_p1_q) + SW'(m_s_q) + SW'(up_b);
    // The sample's own cell at the bottom-right corner.
    bundle.res[2].row = fpsb_pkg::OUT_ROW_W'(m_row_q);
    bundle.res[2].col = fpsb_pkg::OUT_COL_W'(m_col_q);
    bundle.res[2].sum = SW'(left_c) + SW'(m_s_q) + SW'(m_s_q) + SW'(m_s_q) + SW'(up_c);
  end

  // Drop samples that complete no cell; others wait for a free bundle slot.
  assign m_adv   = m_valid_q && ((bundle.mask == 3'b000) || rq_free);
  assign rq_load = m_adv && (bundle.mask != 3'b000);

  fpsb_result_queue u_result_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (rq_load),
    .bundle_i      (bundle),
    .free_o        (rq_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .average_o     (average_o),
    .last_of_run_o (last_of_run_o)
  );

  // Frame position stays inside the live grid.
  a_col_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LW_W'(col_q) < lw)
    else $error("column counter beyond live width");

  a_row_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LH_W'(row_q) < lh)
    else $error("row counter beyond live height");

  // The final sample of a frame returns position and store roles to the start.
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && last_col && last_row && !cfg_we_i)
      |=> (row_q == '0) && (col_q == '0) && !sel_q)
    else $error("frame end did not restart position");

  // A held sample keeps its position until it moves on.
  a_hold_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_adv) |=> m_valid_q && $stable(m_col_q) && $stable(m_row_q))
    else $error("held sample lost its position");

endmodule

// File: rtl/fpsb_line_store.sv
// Two line stores of the stencil blur with swappable older/newer roles.
// Depends on fpsb_pkg for the sample width and the default depth.
module fpsb_line_store #(
  parameter int  DEPTH = fpsb_pkg::MAX_WIDTH_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             access_i,
  input  logic                             sel_i,
  input  logic [AW-1:0]                    addr_c_i,
  input  logic [AW-1:0]                    addr_r_i,
  input  logic [fpsb_pkg::SAMPLE_BITS-1:0] wr_data_i,
  output logic [fpsb_pkg::SAMPLE_BITS-1:0] news_c_o,
  output logic [fpsb_pkg::SAMPLE_BITS-1:0] news_r_o,
  output logic [fpsb_pkg::SAMPLE_BITS-1:0] olds_c_o
);

  logic [fpsb_pkg::SAMPLE_BITS-1:0] mem0 [DEPTH];
  logic [fpsb_pkg::SAMPLE_BITS-1:0] mem1 [DEPTH];
  logic [fpsb_pkg::SAMPLE_BITS-1:0] rd0c_q, rd0r_q, rd1c_q, rd1r_q;
  logic                             sel_q;

  // Read-first: the older row entry is read in the same edge it is replaced.
  always_ff @(posedge clk_i) begin
    if (access_i) begin
      rd0c_q <= mem0[addr_c_i];
      rd0r_q <= mem0[addr_r_i];
      if (!sel_i) begin
        mem0[addr_c_i] <= wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (access_i) begin
      rd1c_q <= mem1[addr_c_i];
      rd1r_q <= mem1[addr_r_i];
      if (sel_i) begin
        mem1[addr_c_i] <= wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (access_i) begin
      sel_q <= sel_i;
    end
  end

  assign olds_c_o = sel_q ? rd1c_q : rd0c_q;
  assign news_c_o = sel_q ? rd0c_q : rd1c_q;
  assign news_r_o = sel_q ? rd0r_q : rd1r_q;

endmodule

// File: rtl/fpsb_result_queue.sv
// Result bundle holder and output register: drains up to three results per
// sample, one per unstalled cycle, dividing each sum by five. Uses fpsb_pkg.
module fpsb_result_queue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  fpsb_pkg::bundle_t                bundle_i,
  output logic                             free_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [fpsb_pkg::OUT_ROW_W-1:0]   out_row_o,
  output logic [fpsb_pkg::OUT_COL_W-1:0]   out_col_o,
  output logic [fpsb_pkg::SAMPLE_BITS-1:0] average_o,
  output logic                             last_of_run_o
);

  logic [2:0]              b_mask_q;
  fpsb_pkg::result_t [2:0] b_res_q;
  logic                    o_valid_q;
  logic [2:0]              pick;
  logic [1:0]              pick_idx;
  logic [2:0]              remain;
  logic                    o_load;
  logic                    emit;

  always_comb begin
    pick     = 3'b000;
    pick_idx = 2'd0;
    priority if (b_mask_q[0]) begin
      pick     = 3'b001;
      pick_idx = 2'd0;
    end else if (b_mask_q[1]) begin
      pick     = 3'b010;
      pick_idx = 2'd1;
    end else if (b_mask_q[2]) begin
      pick     = 3'b100;
      pick_idx = 2'd2;
    end
  end

  assign remain = b_mask_q & ~pick;
  assign o_load = !o_valid_q || !out_stall_i;
  assign emit   = (b_mask_q != 3'b000) && o_load;
  assign free_o = (b_mask_q == 3'b000) || (emit && (remain == 3'b000));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_mask_q  <= 3'b000;
      o_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        b_mask_q <= bundle_i.mask;
      end else if (emit) begin
        b_mask_q <= remain;
      end
      if (o_load) begin
        o_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      b_res_q <= bundle_i.res;
    end
    if (emit) begin
      out_row_o     <= b_res_q[pick_idx].row;
      out_col_o     <= b_res_q[pick_idx].col;
      average_o     <= fpsb_pkg::div5(b_res_q[pick_idx].sum);
      last_of_run_o <= (remain == 3'b000);
    end
  end

  assign out_valid_o = o_valid_q;

endmodule
